[rtl/crp_pkg.sv]
// crp_pkg: shared constants, codes and types for the cooldown resource pool
// no dependencies; imported by every module of the block
`default_nettype none
package crp_pkg;

	localparam int POOL_SIZE = 64;
	localparam int IDX_W     = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int CNT_W     = $clog2(POOL_SIZE + 1);
	localparam int TIME_W    = 48;

	// operation codes
	localparam logic [1:0] FN_LOAD    = 2'd0;
	localparam logic [1:0] FN_ADVANCE = 2'd1;
	localparam logic [1:0] FN_CONSUME = 2'd2;

	// result status codes
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_GRANTED = 2'd1;
	localparam logic [1:0] ST_NOMATCH = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	typedef struct packed {
		logic [1:0]        func;
		logic [15:0]       res_id;
		logic [31:0]       res_price;
		logic [31:0]       res_cooldown;
		logic [TIME_W-1:0] now_time;
		logic [31:0]       budget;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] granted_id;
		logic [31:0] granted_price;
	} rsp_t;

	// per-slot static data written on load
	typedef struct packed {
		logic [15:0] ident;
		logic [31:0] price;
		logic [31:0] cooldown;
	} info_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;    // latch item, restart scan
		logic scan_step;  // read next slot
		logic finish;     // apply item effect, issue result
	} ctl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic scan_last;  // slot being read is the last one
	} dp_stat_t;

endpackage
`default_nettype wire

[rtl/crp_ctrl.sv]
// crp_ctrl: sequencing state machine of the cooldown resource pool
// depends on crp_pkg
`default_nettype none
module crp_ctrl
	import crp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] func,
	input  wire dp_stat_t   stat,
	output logic            busy,
	output ctl_cmd_t        cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_DRAIN  = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (func == FN_ADVANCE || func == FN_CONSUME)
						state_d = S_SCAN;
					else
						state_d = S_FINISH;
				end
			end
			S_SCAN: begin
				if (stat.scan_last)
					state_d = S_DRAIN;
			end
			S_DRAIN:  state_d = S_FINISH;
			S_FINISH: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		cmd.capture   = accept;
		cmd.scan_step = (state_q == S_SCAN);
		cmd.finish    = (state_q == S_FINISH);
	end

endmodule
`default_nettype wire

[rtl/crp_datapath.sv]
// crp_datapath: slot memories, cooling flags, scan pipe and result register
// depends on crp_pkg
`default_nettype none
module crp_datapath
	import crp_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire req_t     req,
	input  wire ctl_cmd_t cmd,
	output dp_stat_t      stat,
	output logic          done,
	output rsp_t          rsp
);

	// latched item
	req_t req_q;

	// slot storage
	info_t             info_mem [POOL_SIZE];
	logic [TIME_W-1:0] ready_mem [POOL_SIZE];
	logic [POOL_SIZE-1:0] cooling_q;
	logic [CNT_W-1:0]  count_q;

	// scan
	logic [IDX_W-1:0]  addr_q;
	logic              valid_s1;
	logic [IDX_W-1:0]  idx_s1;
	info_t             info_s1;
	logic [TIME_W-1:0] ready_s1;

	// best candidate
	logic              found_q;
	logic [IDX_W-1:0]  best_idx_q;
	info_t             best_q;

	logic              used_s1;
	logic              full;
	logic              load_we;
	logic              grant;
	logic              release_s1;
	logic              better_s1;
	logic [TIME_W:0]   ready_sum;
	logic [TIME_W-1:0] ready_new;
	rsp_t              rsp_d;

	assign stat.scan_last = (addr_q == IDX_W'(POOL_SIZE - 1));

	assign full    = (count_q == CNT_W'(POOL_SIZE));
	assign load_we = cmd.finish && (req_q.func == FN_LOAD) && !full;
	assign grant   = cmd.finish && (req_q.func == FN_CONSUME) && found_q;

	assign used_s1 = (CNT_W'(idx_s1) < count_q);

	assign release_s1 = valid_s1 && (req_q.func == FN_ADVANCE) && used_s1 &&
		cooling_q[idx_s1] && (ready_s1 <= req_q.now_time);

	assign better_s1 = valid_s1 && (req_q.func == FN_CONSUME) && used_s1 &&
		!cooling_q[idx_s1] && (info_s1.price <= req_q.budget) &&
		(!found_q || (info_s1.price > best_q.price));

	// ready time saturates at the top of the time range
	assign ready_sum = {1'b0, req_q.now_time} + (TIME_W + 1)'(best_q.cooldown);
	assign ready_new = ready_sum[TIME_W] ? '1 : ready_sum[TIME_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.capture)
			req_q <= req;
	end

	// memories
	always_ff @(posedge clk) begin
		if (load_we)
			info_mem[count_q[IDX_W-1:0]] <= '{ident: req_q.res_id,
				price: req_q.res_price, cooldown: req_q.res_cooldown};
		if (cmd.scan_step)
			info_s1 <= info_mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (grant)
			ready_mem[best_idx_q] <= ready_new;
		if (cmd.scan_step)
			ready_s1 <= ready_mem[addr_q];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cooling_q <= '0;
			count_q   <= '0;
			addr_q    <= '0;
			valid_s1  <= 1'b0;
			idx_s1    <= '0;
			found_q   <= 1'b0;
			done      <= 1'b0;
		end else begin
			valid_s1 <= cmd.scan_step;
			done     <= cmd.finish;
			if (cmd.capture) begin
				addr_q  <= '0;
				found_q <= 1'b0;
			end else if (cmd.scan_step) begin
				addr_q <= addr_q + 1'b1;
			end
			if (cmd.scan_step)
				idx_s1 <= addr_q;
			if (better_s1)
				found_q <= 1'b1;
			if (release_s1)
				cooling_q[idx_s1] <= 1'b0;
			if (load_we) begin
				cooling_q[count_q[IDX_W-1:0]] <= 1'b0;
				count_q <= count_q + 1'b1;
			end
			if (grant)
				cooling_q[best_idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (better_s1) begin
			best_idx_q <= idx_s1;
			best_q     <= info_s1;
		end
	end

	// result of the item being finished
	always_comb begin
		rsp_d        = '0;
		rsp_d.status = ST_DONE;
		case (req_q.func)
			FN_LOAD: begin
				if (full)
					rsp_d.status = ST_FULL;
			end
			FN_CONSUME: begin
				if (found_q) begin
					rsp_d.status        = ST_GRANTED;
					rsp_d.granted_id    = best_q.ident;
					rsp_d.granted_price = best_q.price;
				end else begin
					rsp_d.status = ST_NOMATCH;
				end
			end
			default: rsp_d.status = ST_DONE;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish)
			rsp <= rsp_d;
	end

endmodule
`default_nettype wire

[rtl/cooldown_resource_pool_unit.sv]
// cooldown_resource_pool_unit: top level of the cooldown resource pool
// depends on crp_pkg, crp_ctrl and crp_datapath
//
// An item is taken when start is high and busy is low. Each item gives one
// result, shown on rsp for a single cycle with done high; the receiver cannot
// stall, so it must take rsp whenever done is seen. A load (or the unused
// operation code) goes straight from idle to the finish state, and its result
// appears in the cycle after that. An advance or consume walks all 64 slots
// one per cycle through the single read port of the slot memories; a drain
// state empties the read pipe and a finish state applies any grant; busy
// then drops and the result follows in the next cycle, so a new item can be
// taken while a result is on rsp. No clearing pass is needed after reset.
`default_nettype none
module cooldown_resource_pool_unit
	import crp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t req,
	output logic      done,
	output rsp_t      rsp
);

	ctl_cmd_t cmd;   // sequencing commands
	dp_stat_t stat;  // scan progress back to the controller

	// state machine: idle, slot scan, pipe drain, finish
	crp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (req.func),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	// slot memories, cooling flags, best-price search and result register
	crp_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.done   (done),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire
